FILE: rtl/lli_pkg.sv
package lli_pkg;

    // Node pool
    localparam int POOL_DEPTH = 64;
    localparam int IDX_W      = $clog2(POOL_DEPTH);
    localparam int PTR_W      = $clog2(POOL_DEPTH + 1);
    localparam logic [PTR_W-1:0] NULL_IDX = PTR_W'(POOL_DEPTH);

    // Field widths
    localparam int CMD_W  = 2;
    localparam int DATA_W = 32;
    localparam int LEN_W  = 7;
    localparam int STAT_W = 2;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_APPEND = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DUMP   = 2'd2;

    // Status codes
    localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
    localparam logic [STAT_W-1:0] ST_INVALID = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL    = 2'd2;
    localparam logic [STAT_W-1:0] ST_EMPTY   = 2'd3;

    // Operation kinds handed from front to back
    localparam int KIND_W = 3;
    localparam logic [KIND_W-1:0] OP_REPORT   = 3'd0;
    localparam logic [KIND_W-1:0] OP_INS_HEAD = 3'd1;
    localparam logic [KIND_W-1:0] OP_INS_TAIL = 3'd2;
    localparam logic [KIND_W-1:0] OP_INS_MID  = 3'd3;
    localparam logic [KIND_W-1:0] OP_DUMP     = 3'd4;

    // Operation queue
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        logic [CMD_W-1:0]         command;
        logic signed [DATA_W-1:0] value;
        logic [LEN_W-1:0]         position;
    } in_word_t;

    typedef struct packed {
        logic [STAT_W-1:0]        status;
        logic [LEN_W-1:0]         length;
        logic signed [DATA_W-1:0] item_value;
        logic                     last;
    } out_word_t;

    typedef struct packed {
        logic [KIND_W-1:0]        kind;
        logic [STAT_W-1:0]        status;
        logic [LEN_W-1:0]         length;  // list length after this op
        logic signed [DATA_W-1:0] value;
        logic [LEN_W-1:0]         hops;    // link hops to the node before the new one
        logic [IDX_W-1:0]         fresh;   // node taken by an insert
    } op_t;

endpackage

FILE: rtl/linked_list_insert_engine_core.sv
// Singly linked list in a 64-node pool. Command words: insert at position, append
// at tail, dump. Insert and append answer with one word (status, new length, last
// set); dump answers with one word per node in list order, last set on the final
// one, or a single list-empty word. A front end decides each outcome from the node
// count and queues it (two entries) for the back end, which does the pointer work
// in two single-port-read memories (values, links). A head insert and an append
// (a tail pointer is kept) need no walk; an insert at position p walks the list
// since the back end follows one link per memory read, and a dump sends one node
// per cycle while the output is not stalled. No clearing pass after reset: the
// pool is usable as soon as reset is released.
module linked_list_insert_engine_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    output logic               cmd_stall,
    input  lli_pkg::in_word_t  cmd_word,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output lli_pkg::out_word_t rsp_word
);
    import lli_pkg::*;

    logic q_full;
    logic push;
    op_t  push_op;
    logic pop;
    logic avail;
    op_t  pop_op;

    lli_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd_word  (cmd_word),
        .q_full    (q_full),
        .push      (push),
        .push_op   (push_op)
    );

    lli_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .push_op (push_op),
        .full    (q_full),
        .pop     (pop),
        .avail   (avail),
        .pop_op  (pop_op)
    );

    lli_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .avail     (avail),
        .pop_op    (pop_op),
        .pop       (pop),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_word  (rsp_word)
    );

endmodule

FILE: rtl/lli_ram.sv
module lli_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/lli_front.sv
module lli_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cmd_valid,
    output logic             cmd_stall,
    input  lli_pkg::in_word_t cmd_word,
    input  logic             q_full,
    output logic             push,
    output lli_pkg::op_t     push_op
);
    import lli_pkg::*;

    // Nodes are never freed, so the count alone decides every outcome and the
    // index of the next free node; the back end only does the pointer work.
    logic [PTR_W-1:0] count_reg;
    logic [PTR_W-1:0] count_next;
    logic [31:0]      pos;
    logic [31:0]      cnt32;
    op_t              op;

    assign cmd_stall = q_full;
    assign push      = cmd_valid && !q_full;
    assign cnt32     = 32'(count_reg);

    always_comb
    begin
        op            = '0;
        op.value      = cmd_word.value;
        op.fresh      = count_reg[IDX_W-1:0];
        op.length     = LEN_W'(count_reg);
        op.kind       = OP_REPORT;
        op.status     = ST_OK;
        count_next    = count_reg;
        pos           = (cmd_word.command == CMD_INSERT) ? 32'(cmd_word.position) : cnt32;
        unique case (cmd_word.command)
            CMD_INSERT, CMD_APPEND:
            begin
                if (cnt32 >= POOL_DEPTH)
                begin
                    op.status = ST_FULL;
                end
                else if (pos > cnt32)
                begin
                    op.status = ST_INVALID;
                end
                else
                begin
                    count_next = count_reg + 1'b1;
                    op.length  = LEN_W'(count_next);
                    op.hops    = LEN_W'(pos - 32'd1);
                    if (pos == 32'd0)
                    begin
                        op.kind = OP_INS_HEAD;
                    end
                    else if (pos == cnt32)
                    begin
                        op.kind = OP_INS_TAIL;
                    end
                    else
                    begin
                        op.kind = OP_INS_MID;
                    end
                end
            end
            CMD_DUMP:
            begin
                if (cnt32 == 32'd0)
                begin
                    op.status = ST_EMPTY;
                end
                else
                begin
                    op.kind = OP_DUMP;
                end
            end
            default:
            begin
                op.status = ST_OK;
            end
        endcase
    end

    assign push_op = op;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (push)
        begin
            count_reg <= count_next;
        end
    end

endmodule

FILE: rtl/lli_queue.sv
module lli_queue (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  lli_pkg::op_t push_op,
    output logic         full,
    input  logic         pop,
    output logic         avail,
    output lli_pkg::op_t pop_op
);
    import lli_pkg::*;

    op_t               entries_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W:0]   fill_reg;

    function automatic logic [QPTR_W-1:0] bump(input logic [QPTR_W-1:0] p);
        return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign full   = (fill_reg == (QPTR_W + 1)'(QUEUE_DEPTH));
    assign avail  = (fill_reg != '0);
    assign pop_op = entries_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_op;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= bump(wr_ptr_reg);
            end
            if (pop)
            begin
                rd_ptr_reg <= bump(rd_ptr_reg);
            end
            if (push && !pop)
            begin
                fill_reg <= fill_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                fill_reg <= fill_reg - 1'b1;
            end
        end
    end

endmodule

FILE: rtl/lli_back.sv
module lli_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              avail,
    input  lli_pkg::op_t      pop_op,
    output logic              pop,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output lli_pkg::out_word_t rsp_word
);
    import lli_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EXEC = 3'd1;
    localparam logic [2:0] S_WALK = 3'd2;
    localparam logic [2:0] S_LINK = 3'd3;
    localparam logic [2:0] S_DUMP = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    logic [2:0]        state_reg, state_next;
    op_t               op_reg, op_next;
    logic [PTR_W-1:0]  head_reg, head_next;
    logic [IDX_W-1:0]  tail_reg, tail_next;
    logic [IDX_W-1:0]  cur_reg, cur_next;
    logic [LEN_W-1:0]  cnt_reg, cnt_next;
    logic              out_valid_reg;
    out_word_t         out_word_reg;

    logic              out_free;
    logic              emit;
    out_word_t         emit_word;

    logic              val_we;
    logic              link_we;
    logic [IDX_W-1:0]  link_waddr;
    logic [PTR_W-1:0]  link_wdata;
    logic [IDX_W-1:0]  raddr;
    logic [DATA_W-1:0] val_rdata;
    logic [PTR_W-1:0]  link_rdata;
    logic [IDX_W-1:0]  link_idx;
    logic [IDX_W-1:0]  head_idx;

    lli_ram #(.WIDTH(DATA_W), .DEPTH(POOL_DEPTH)) u_values (
        .clk   (clk),
        .we    (val_we),
        .waddr (op_reg.fresh),
        .wdata (op_reg.value),
        .raddr (raddr),
        .rdata (val_rdata)
    );

    lli_ram #(.WIDTH(PTR_W), .DEPTH(POOL_DEPTH)) u_links (
        .clk   (clk),
        .we    (link_we),
        .waddr (link_waddr),
        .wdata (link_wdata),
        .raddr (raddr),
        .rdata (link_rdata)
    );

    // walks only ever reach live nodes, so the null marker never lands here
    assign link_idx = link_rdata[IDX_W-1:0];
    assign head_idx = head_reg[IDX_W-1:0];
    assign out_free = !out_valid_reg || !rsp_stall;

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        head_next  = head_reg;
        tail_next  = tail_reg;
        cur_next   = cur_reg;
        cnt_next   = cnt_reg;
        pop        = 1'b0;
        emit       = 1'b0;
        emit_word  = '0;
        val_we     = 1'b0;
        link_we    = 1'b0;
        link_waddr = op_reg.fresh;
        link_wdata = NULL_IDX;
        raddr      = cur_reg;   // holding the address keeps the read data steady
        unique case (state_reg)
            S_IDLE:
            begin
                if (avail)
                begin
                    pop        = 1'b1;
                    op_next    = pop_op;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                unique case (op_reg.kind)
                    OP_INS_HEAD:
                    begin
                        val_we     = 1'b1;
                        link_we    = 1'b1;
                        link_wdata = head_reg;
                        head_next  = PTR_W'(op_reg.fresh);
                        if (head_reg == NULL_IDX)
                        begin
                            tail_next = op_reg.fresh;
                        end
                        state_next = S_DONE;
                    end
                    OP_INS_TAIL:
                    begin
                        val_we     = 1'b1;
                        link_we    = 1'b1;
                        cur_next   = tail_reg;
                        state_next = S_LINK;
                    end
                    OP_INS_MID:
                    begin
                        val_we     = 1'b1;
                        raddr      = head_idx;
                        cur_next   = head_idx;
                        cnt_next   = op_reg.hops;
                        state_next = S_WALK;
                    end
                    OP_DUMP:
                    begin
                        raddr      = head_idx;
                        cur_next   = head_idx;
                        cnt_next   = op_reg.length;
                        state_next = S_DUMP;
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end
            S_WALK:
            begin
                // link_rdata is the successor of cur_reg
                if (cnt_reg == '0)
                begin
                    link_we    = 1'b1;
                    link_wdata = link_rdata;
                    state_next = S_LINK;
                end
                else
                begin
                    raddr    = link_idx;
                    cur_next = link_idx;
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            S_LINK:
            begin
                link_we    = 1'b1;
                link_waddr = cur_reg;
                link_wdata = PTR_W'(op_reg.fresh);
                if (op_reg.kind == OP_INS_TAIL)
                begin
                    tail_next = op_reg.fresh;
                end
                state_next = S_DONE;
            end
            S_DUMP:
            begin
                if (out_free)
                begin
                    emit                 = 1'b1;
                    emit_word.status     = ST_OK;
                    emit_word.length     = op_reg.length;
                    emit_word.item_value = val_rdata;
                    emit_word.last       = (cnt_reg == LEN_W'(1));
                    if (cnt_reg == LEN_W'(1))
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        raddr    = link_idx;
                        cur_next = link_idx;
                        cnt_next = cnt_reg - 1'b1;
                    end
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    emit             = 1'b1;
                    emit_word.status = op_reg.status;
                    emit_word.length = op_reg.length;
                    emit_word.last   = 1'b1;
                    state_next       = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= NULL_IDX;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            cnt_reg   <= cnt_next;
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        tail_reg <= tail_next;
        cur_reg  <= cur_next;
        if (emit)
        begin
            out_word_reg <= emit_word;
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp_word  = out_word_reg;

endmodule

FILE: rtl/lli_checker.sv
module lli_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               rsp_valid,
    input logic               rsp_stall,
    input lli_pkg::out_word_t rsp_word
);
    import lli_pkg::*;

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid)
        else $error("response word dropped while stalled");

    a_rsp_stable: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> $stable(rsp_word))
        else $error("stalled response word changed");

    a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> 32'(rsp_word.length) <= POOL_DEPTH)
        else $error("length beyond pool depth");

    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_word.status == ST_EMPTY |->
            rsp_word.length == '0 && rsp_word.last)
        else $error("empty report with nonzero length or not last");

    a_dump_body: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_word.last |->
            rsp_word.status == ST_OK && rsp_word.length != '0)
        else $error("non-final word outside a dump of a non-empty list");

endmodule

bind linked_list_insert_engine_core lli_checker u_chk (.*);

FILE: tb/sv/linked_list_insert_engine_core_tb.sv
module linked_list_insert_engine_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lli_pkg::*;

    // Command code three is unused by the block: it answers with the length only
    localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;
    localparam int DUMP_MAX     = 64;
    localparam int N_RAND       = 451;
    localparam int PHASE_LEN    = 150;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 200;

    typedef struct {
        in_word_t  w;
        bit        typed;
        out_word_t exp;
    } dir_row_t;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      cmd_valid = 1'b0;
    logic      cmd_stall;
    in_word_t  cmd_word  = '0;
    logic      rsp_valid;
    logic      rsp_stall = 1'b0;
    out_word_t rsp_word;

    // shadow copy of the list
    logic signed [DATA_W-1:0] list_val  [POOL_DEPTH];
    logic [PTR_W-1:0]         list_link [POOL_DEPTH];
    logic [PTR_W-1:0]         list_head  = NULL_IDX;
    int                       list_count = 0;

    out_word_t rsp_due [$];
    int        errors    = 0;
    int        send_idle = 11;
    int        recv_idle = 49;
    int        phase     = 1;
    bit        hold_done = 1'b0;
    int        hold_left = 0;

    linked_list_insert_engine_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd_word  (cmd_word),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_word  (rsp_word)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    task automatic note_error(input string msg);
        errors++;
        $display("%0t mismatch: %s", $time, msg);
    endtask

    // full check comes before the position check
    function automatic logic [STAT_W-1:0] list_splice(int pos, logic signed [DATA_W-1:0] v);
        int fresh;
        int prev;
        int i;
        if (list_count >= POOL_DEPTH)
            return ST_FULL;
        if (pos > list_count)
            return ST_INVALID;
        fresh = list_count;
        list_val[fresh] = v;
        if (pos == 0)
        begin
            list_link[fresh] = list_head;
            list_head = PTR_W'(fresh);
        end
        else
        begin
            prev = list_head;
            for (i = 1; i < pos; i++)
            begin
                if (prev >= POOL_DEPTH)
                    return ST_INVALID;
                prev = list_link[prev];
            end
            if (prev >= POOL_DEPTH)
                return ST_INVALID;
            list_link[fresh] = list_link[prev];
            list_link[prev] = PTR_W'(fresh);
        end
        list_count++;
        return ST_OK;
    endfunction

    function automatic void list_apply(in_word_t w);
        out_word_t r;
        int cur;
        int k;
        int lim;
        r = '0;
        r.last = 1'b1;
        case (w.command)
            CMD_INSERT, CMD_APPEND:
            begin
                r.status = list_splice(w.command == CMD_INSERT ? int'(w.position) : list_count,
                                       w.value);
                r.length = LEN_W'(list_count);
                rsp_due.push_back(r);
            end
            CMD_DUMP:
            begin
                r.length = LEN_W'(list_count);
                if (list_count == 0 || list_head >= POOL_DEPTH)
                begin
                    r.status = ST_EMPTY;
                    rsp_due.push_back(r);
                end
                else
                begin
                    lim = list_count < DUMP_MAX ? list_count : DUMP_MAX;
                    cur = list_head;
                    k = 0;
                    while (cur < POOL_DEPTH && k < lim)
                    begin
                        r.status = ST_OK;
                        r.item_value = list_val[cur];
                        r.last = (k + 1 == lim) || (list_link[cur] >= POOL_DEPTH);
                        rsp_due.push_back(r);
                        k++;
                        cur = list_link[cur];
                    end
                end
            end
            default:
            begin
                r.status = ST_OK;
                r.length = LEN_W'(list_count);
                rsp_due.push_back(r);
            end
        endcase
    endfunction

    function automatic dir_row_t mk_row(logic [CMD_W-1:0] c, logic signed [DATA_W-1:0] v,
                                        logic [LEN_W-1:0] p, bit typed,
                                        logic [STAT_W-1:0] st, logic [LEN_W-1:0] len);
        dir_row_t row;
        row.w.command = c;
        row.w.value = v;
        row.w.position = p;
        row.typed = typed;
        row.exp.status = st;
        row.exp.length = len;
        row.exp.item_value = '0;
        row.exp.last = 1'b1;
        return row;
    endfunction

    function automatic in_word_t rand_cmd();
        in_word_t w;
        int r;
        r = $urandom_range(99);
        w.command = r < 22 ? CMD_INSERT : r < 34 ? CMD_APPEND : r < 94 ? CMD_DUMP : CMD_SPARE;
        case ($urandom_range(7))
            0:       w.value = 32'h8000_0000;
            1:       w.value = 32'h7FFF_FFFF;
            2:       w.value = 32'hFFFF_FFFF;
            3:       w.value = '0;
            default: w.value = $urandom;
        endcase
        // mostly positions within the list, some anywhere in the field
        if ($urandom_range(3) == 0)
            w.position = LEN_W'($urandom_range(127));
        else
            w.position = LEN_W'($urandom_range(list_count));
        return w;
    endfunction

    task automatic send_cmd(input in_word_t w, input bit typed, input out_word_t exp);
        while ($urandom_range(99) < send_idle)
        begin
            cmd_valid <= 1'b0;
            @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd_word <= w;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
        list_apply(w);
        if (typed)
        begin
            void'(rsp_due.pop_back());
            rsp_due.push_back(exp);
        end
    endtask

    task automatic check_rsp(input out_word_t got);
        out_word_t want;
        if (rsp_due.size() == 0)
        begin
            note_error($sformatf("unexpected word status=%0d length=%0d value=%0d last=%0d",
                                 got.status, got.length, got.item_value, got.last));
            return;
        end
        want = rsp_due.pop_front();
        if (got.status !== want.status)
            note_error($sformatf("status %0d, want %0d", got.status, want.status));
        if (got.length !== want.length)
            note_error($sformatf("length %0d, want %0d", got.length, want.length));
        if (got.item_value !== want.item_value)
            note_error($sformatf("item_value %0d, want %0d", got.item_value, want.item_value));
        if (got.last !== want.last)
            note_error($sformatf("last %0d, want %0d", got.last, want.last));
    endtask

    // response side: check accepted words, drive stall, one long hold-off in phase 3
    always @(posedge clk)
    begin
        if (rsp_valid && !rsp_stall)
            check_rsp(rsp_word);
        if (phase == 3 && !hold_done)
        begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
        end
        if (hold_left > 0)
        begin
            rsp_stall <= 1'b1;
            hold_left--;
        end
        else
        begin
            rsp_stall <= ($urandom_range(99) < recv_idle);
        end
    end

    initial
    begin
        dir_row_t tab [$];
        int i;
        foreach (list_val[j])
        begin
            list_val[j] = '0;
            list_link[j] = '0;
        end
        tab.push_back(mk_row(CMD_DUMP,   0,             7'd0,   1, ST_EMPTY,   7'd0));
        tab.push_back(mk_row(CMD_INSERT, 5,             7'd1,   1, ST_INVALID, 7'd0));
        tab.push_back(mk_row(CMD_SPARE,  32'hFFFF_FFFF, 7'd127, 1, ST_OK,      7'd0));
        tab.push_back(mk_row(CMD_INSERT, 32'h8000_0000, 7'd0,   1, ST_OK,      7'd1));
        tab.push_back(mk_row(CMD_APPEND, 32'h7FFF_FFFF, 7'd0,   1, ST_OK,      7'd2));
        tab.push_back(mk_row(CMD_INSERT, -1,            7'd2,   0, ST_OK,      7'd0));
        tab.push_back(mk_row(CMD_INSERT, 0,             7'd1,   0, ST_OK,      7'd0));
        tab.push_back(mk_row(CMD_INSERT, 9,             7'd127, 1, ST_INVALID, 7'd4));
        tab.push_back(mk_row(CMD_INSERT, 9,             7'd5,   1, ST_INVALID, 7'd4));
        tab.push_back(mk_row(CMD_INSERT, 32'h1234,      7'd4,   0, ST_OK,      7'd0));
        tab.push_back(mk_row(CMD_DUMP,   0,             7'd0,   0, ST_OK,      7'd0));
        tab.push_back(mk_row(CMD_INSERT, 1,             7'd0,   0, ST_OK,      7'd0));
        tab.push_back(mk_row(CMD_INSERT, 32'h5555_5555, 7'd3,   0, ST_OK,      7'd0));
        tab.push_back(mk_row(CMD_APPEND, 32'hAAAA_AAAA, 7'd0,   0, ST_OK,      7'd0));
        tab.push_back(mk_row(CMD_DUMP,   0,             7'd0,   0, ST_OK,      7'd0));
        tab.push_back(mk_row(CMD_SPARE,  0,             7'd0,   1, ST_OK,      7'd8));
        tab.push_back(mk_row(CMD_INSERT, 3,             7'd64,  1, ST_INVALID, 7'd8));
        tab.push_back(mk_row(CMD_APPEND, 0,             7'd127, 0, ST_OK,      7'd0));
        tab.push_back(mk_row(CMD_DUMP,   -7,            7'd127, 0, ST_OK,      7'd0));

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (tab[j])
            send_cmd(tab[j].w, tab[j].typed, tab[j].exp);

        for (i = 0; i < N_RAND; i++)
        begin
            if (i == PHASE_LEN)
            begin
                send_idle = 49;
                recv_idle = 11;
            end
            if (i == 2 * PHASE_LEN)
            begin
                send_idle = 0;
                recv_idle = 0;
                phase = 3;
            end
            send_cmd(rand_cmd(), 1'b0, '0);
        end
        cmd_valid <= 1'b0;

        while (rsp_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
